// File: rtl/core/modular_inverse_ext_euclid_unit_macros.svh
// Assertion macros used by the checker file of the modular inverse unit.
// Needs nothing else; each macro expands to one concurrent assertion.
`ifndef MODULAR_INVERSE_EXT_EUCLID_UNIT_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MODINV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("modinv assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MODINV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("modinv assertion failed");

`endif

// File: rtl/core/modinv_pkg.sv
// Shared types for the modular inverse unit: controller commands and datapath status.
// No dependencies.
`default_nettype none

package modinv_pkg;

  // Modulus value after reset (truncated to the configured width).
  localparam int ModulusReset = 26;

  // Commands from the controller to the datapath, at most one high per cycle.
  typedef struct packed {
    logic load;        // take a new item and set up the remainder sequence
    logic iter_start;  // begin one Euclid step
    logic align;       // double the shifted divisor and coefficient
    logic desc;        // one shift-subtract step of the quotient
    logic fin_add;     // lift a negative coefficient into range
    logic fin_sub;     // final reduction below the modulus
    logic capture;     // load the output register
  } modinv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic r1_zero;     // remainder sequence has ended
    logic align_ok;    // divisor can be doubled once more
    logic desc_last;   // divisor is back at its unshifted value
  } modinv_status_t;

endpackage

`default_nettype wire

// File: rtl/core/modinv_dp.sv
// Datapath of the modular inverse unit: modulus register, remainder and
// coefficient registers, shift-subtract unit and output register. Uses modinv_pkg.
`default_nettype none

module modinv_dp import modinv_pkg::*; #(
  parameter int WIDTH = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WIDTH-1:0]   cfg_modulus_i,
  input  logic [WIDTH-1:0]   value_i,
  input  modinv_cmd_t        cmd_i,
  output modinv_status_t     status_o,
  output logic [WIDTH-1:0]   inverse_o,
  output logic               invertible_o
);

  // Coefficients are signed and bounded by the modulus in magnitude.
  localparam int TW = WIDTH + 1;

  logic [WIDTH-1:0]        mod_q;
  logic [WIDTH-1:0]        r0_q, r1_q, rem_q, rs_q;
  logic signed [TW-1:0]    t0_q, t1_q, tacc_q, ts_q;
  logic [WIDTH-1:0]        inv_q;
  logic                    ok_q;

  logic                    fits;
  logic [WIDTH-1:0]        rem_n;
  logic signed [TW-1:0]    tacc_n;
  logic signed [TW-1:0]    mod_ext;
  logic                    ok;

  assign mod_ext = signed'({1'b0, mod_q});
  assign fits    = rs_q <= rem_q;
  assign rem_n   = fits ? (rem_q - rs_q) : rem_q;
  assign tacc_n  = fits ? (tacc_q - ts_q) : tacc_q;
  assign ok      = (r0_q == WIDTH'(1)) && (mod_q != '0);

  assign status_o.r1_zero   = r1_q == '0;
  assign status_o.align_ok  = {rs_q, 1'b0} <= {1'b0, rem_q};
  assign status_o.desc_last = rs_q == r1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= WIDTH'(ModulusReset);
    end else if (cfg_we_i) begin
      mod_q <= cfg_modulus_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r0_q <= mod_q;
      r1_q <= value_i;
      t0_q <= '0;
      t1_q <= TW'(1);
    end
    if (cmd_i.iter_start) begin
      rem_q  <= r0_q;
      tacc_q <= t0_q;
      rs_q   <= r1_q;
      ts_q   <= t1_q;
    end
    if (cmd_i.align) begin
      rs_q <= {rs_q[WIDTH-2:0], 1'b0};
      ts_q <= ts_q <<< 1;
    end
    if (cmd_i.desc) begin
      rem_q  <= rem_n;
      tacc_q <= tacc_n;
      if (rs_q == r1_q) begin
        r0_q <= r1_q;
        r1_q <= rem_n;
        t0_q <= t1_q;
        t1_q <= tacc_n;
      end else begin
        rs_q <= rs_q >> 1;
        ts_q <= ts_q >>> 1;
      end
    end
    if (cmd_i.fin_add && t0_q[TW-1]) begin
      t0_q <= t0_q + mod_ext;
    end
    if (cmd_i.fin_sub && (t0_q >= mod_ext)) begin
      t0_q <= t0_q - mod_ext;
    end
    if (cmd_i.capture) begin
      inv_q <= ok ? t0_q[WIDTH-1:0] : '0;
      ok_q  <= ok;
    end
  end

  assign inverse_o    = inv_q;
  assign invertible_o = ok_q;

endmodule

`default_nettype wire

// File: rtl/core/modinv_ctrl.sv
// Controller of the modular inverse unit: sequences the Euclid steps and owns
// the input ready and output valid handshakes. Uses modinv_pkg.
`default_nettype none

module modinv_ctrl import modinv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  modinv_status_t  status_i,
  output modinv_cmd_t     cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StIter  = 3'd1;
  localparam logic [2:0] StAlign = 3'd2;
  localparam logic [2:0] StDesc  = 3'd3;
  localparam logic [2:0] StFAdd  = 3'd4;
  localparam logic [2:0] StFSub  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StIter;
        end
      end
      StIter: begin
        if (status_i.r1_zero) begin
          state_d = StFAdd;
        end else begin
          cmd_o.iter_start = 1'b1;
          state_d          = StAlign;
        end
      end
      StAlign: begin
        if (status_i.align_ok) begin
          cmd_o.align = 1'b1;
        end else begin
          state_d = StDesc;
        end
      end
      StDesc: begin
        cmd_o.desc = 1'b1;
        if (status_i.desc_last) begin
          state_d = StIter;
        end
      end
      StFAdd: begin
        cmd_o.fin_add = 1'b1;
        state_d       = StFSub;
      end
      StFSub: begin
        cmd_o.fin_sub = 1'b1;
        state_d       = StOut;
      end
      StOut: begin
        // Wait until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/core/modular_inverse_ext_euclid_unit.sv
// Modular inverse unit, top level: joins the controller and the datapath.
// Depends on modinv_pkg, modinv_ctrl and modinv_dp.
//
// This block returns, for each input item value_i, the inverse of value_i modulo the
// configured modulus, reduced into 0 to modulus-1, together with invertible_o, which is
// high exactly when the gcd of value_i and the modulus is one. When the value has no
// inverse, and also for a modulus of zero, inverse_o is zero and invertible_o is low; a
// modulus of one gives inverse zero with invertible high. Values at or above the modulus
// are accepted as they are: the Euclid steps reduce them, and a value above the modulus
// costs one extra step with a zero quotient that swaps the pair. The modulus resets to 26
// and is written through the cfg channel, which is always ready; write it only while no
// item is in flight. The block works on one item at a time. Each Euclid step finds its
// quotient bit by bit in one shared shift-subtract unit: a setup step, then the divisor is
// doubled while it still fits under the remainder, then one shift-subtract step per
// quotient bit. Around the Euclid steps lie the load, final reduction and output steps. The
// result sits in an output register, so the next item is taken while the previous result
// still waits; if that result has still not been taken when the next one is done, the unit
// holds in its output step until it is.

`default_nettype none

module modular_inverse_ext_euclid_unit import modinv_pkg::*; #(
  parameter int WIDTH = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write channel (modulus)
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [WIDTH-1:0] cfg_modulus_i,
  // Input item channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] value_i,
  // Result item channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] inverse_o,
  output logic             invertible_o
);

  modinv_cmd_t    cmd;
  modinv_status_t status;

  // The modulus register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  modinv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  modinv_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_modulus_i (cfg_modulus_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .inverse_o     (inverse_o),
    .invertible_o  (invertible_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/modinv_checker.sv
// Port-level checker for the modular inverse unit, bound to the top level.
// Depends on modular_inverse_ext_euclid_unit_macros.svh.
`default_nettype none

`include "modular_inverse_ext_euclid_unit_macros.svh"

module modinv_checker #(
  parameter int WIDTH = 31
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [WIDTH-1:0] inverse_o,
  input logic             invertible_o
);

  // A stalled result keeps its valid and its payload.
  `MODINV_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(inverse_o) && $stable(invertible_o))

  // A value without an inverse always reports zero.
  `MODINV_ASSERT_IMP(a_zero_if_not_inv, clk_i, rst_ni, out_valid_o && !invertible_o, inverse_o == '0)

  // The unit is busy right after it takes an item.
  `MODINV_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // No result can appear in the cycle after an item is taken.
  `MODINV_ASSERT_NXT(a_no_instant_result, clk_i, rst_ni, in_valid_i && in_ready_o, !$rose(out_valid_o))

endmodule

bind modular_inverse_ext_euclid_unit modinv_checker #(.WIDTH(WIDTH)) u_checker (.*);

`default_nettype wire
